@@ hw/rtl/sce_pkg.sv @@
// Shared types, constants and lookup tables for the softmax cross-entropy loss block.
// Holds the exp/log tables, saturation helpers, state and code enums.
// No dependencies.
package sce_pkg;

   localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
   localparam logic [15:0]        LN2_Q16 = 16'd45426;
   localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

   // Result kinds on the result channel
   localparam logic [1:0] RK_LOGPROB = 2'd0;
   localparam logic [1:0] RK_POSLOSS = 2'd1;
   localparam logic [1:0] RK_REDUCED = 2'd2;

   // Reduction modes
   localparam logic [1:0] RED_NONE = 2'd0;
   localparam logic [1:0] RED_MEAN = 2'd1;

   // Input kinds
   localparam logic KIND_WEIGHT = 1'b0;

   // Register indexes (byte address / 4)
   typedef enum logic [2:0] {
      REG_REDUCTION = 3'd0,
      REG_IGN_EN    = 3'd1,
      REG_IGN_LABEL = 3'd2,
      REG_WEIGHT_EN = 3'd3,
      REG_LOGP_EN   = 3'd4
   } reg_index_type;

   // Sequencer states, one-hot
   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_MAXP  = 14'b00000000000010,
      S_EXPP  = 14'b00000000000100,
      S_NORM  = 14'b00000000001000,
      S_LOGM  = 14'b00000000010000,
      S_LOGS  = 14'b00000000100000,
      S_LPRD  = 14'b00000001000000,
      S_LPOUT = 14'b00000010000000,
      S_WRD   = 14'b00000100000000,
      S_LMUL  = 14'b00001000000000,
      S_LACC  = 14'b00010000000000,
      S_POS   = 14'b00100000000000,
      S_DIV   = 14'b01000000000000,
      S_RED   = 14'b10000000000000
   } state_type;

   // exp of the integer part, Q16
   function automatic logic [16:0] exp_int(input logic [3:0] k);
      logic [16:0] v;
      unique case (k)
         4'd0:    v = 17'd65536;
         4'd1:    v = 17'd24109;
         4'd2:    v = 17'd8869;
         4'd3:    v = 17'd3263;
         4'd4:    v = 17'd1200;
         4'd5:    v = 17'd442;
         4'd6:    v = 17'd162;
         4'd7:    v = 17'd60;
         4'd8:    v = 17'd22;
         4'd9:    v = 17'd8;
         4'd10:   v = 17'd3;
         4'd11:   v = 17'd1;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   // exp of the top four fraction bits, Q16
   function automatic logic [16:0] exp_frac(input logic [3:0] j);
      logic [16:0] v;
      unique case (j)
         4'd0:  v = 17'd65536;
         4'd1:  v = 17'd61565;
         4'd2:  v = 17'd57835;
         4'd3:  v = 17'd54331;
         4'd4:  v = 17'd51039;
         4'd5:  v = 17'd47947;
         4'd6:  v = 17'd45042;
         4'd7:  v = 17'd42313;
         4'd8:  v = 17'd39750;
         4'd9:  v = 17'd37341;
         4'd10: v = 17'd35079;
         4'd11: v = 17'd32954;
         4'd12: v = 17'd30957;
         4'd13: v = 17'd29081;
         4'd14: v = 17'd27319;
         4'd15: v = 17'd25664;
      endcase
      return v;
   endfunction

   // ln(1 + i/16), Q16, for i in 0..16
   function automatic logic [15:0] log_tab(input logic [4:0] i);
      logic [15:0] v;
      unique case (i)
         5'd0:    v = 16'd0;
         5'd1:    v = 16'd3973;
         5'd2:    v = 16'd7719;
         5'd3:    v = 16'd11262;
         5'd4:    v = 16'd14624;
         5'd5:    v = 16'd17821;
         5'd6:    v = 16'd20870;
         5'd7:    v = 16'd23783;
         5'd8:    v = 16'd26573;
         5'd9:    v = 16'd29248;
         5'd10:   v = 16'd31818;
         5'd11:   v = 16'd34292;
         5'd12:   v = 16'd36675;
         5'd13:   v = 16'd38975;
         5'd14:   v = 16'd41196;
         5'd15:   v = 16'd43345;
         default: v = 16'd45426;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -66'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
      if (v > 66'(S48_MAX)) return S48_MAX;
      if (v < 66'(S48_MIN)) return S48_MIN;
      return v[47:0];
   endfunction

endpackage

@@ hw/rtl/sce_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the score buffer and the class weight table; no dependencies.
module sce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

@@ hw/rtl/softmax_cross_entropy_loss.sv @@
// Softmax cross-entropy loss: top level with sequencer, datapath and register port.
// Depends on sce_pkg and sce_ram.
//
// Scores of a position stream in one per cycle while the sequencer is idle and land
// in a score RAM; class weights (tuser kind 0) go to a weight RAM. On the score
// flagged tlast the sequencer walks the buffered N scores three times through the
// single score RAM read port: a max pass, an exp pass through a two-multiplier
// pipeline, then a per-class log-probability pass (a read state and an output state
// per class, held when log-probabilities are enabled and the result channel stalls).
// Between them the log step normalizes the exp sum one bit per cycle and then
// passes S_LOGM and S_LOGS. The loss steps S_WRD, S_LMUL and S_LACC follow, and a
// loss or reduced result leaves through S_POS or S_RED. A mean result adds a
// bit-serial restoring divide. Weight writes and non-final scores are taken in
// S_IDLE without leaving it.
module softmax_cross_entropy_loss
   import sce_pkg::*;
#(
   parameter int MAX_CLASSES = 32
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // class_slot[5:0], sample[37:6], label[53:38],
                                    // last_position[54], zero[55]
   input  logic        req_tuser,   // kind[0]
   input  logic        req_tlast,   // last_class
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // amount[31:0]
   output logic [2:0]  rsp_tuser,   // result_kind[1:0], not_a_number[2]
   output logic        rsp_tlast,   // final_res
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int CW = $clog2(MAX_CLASSES + 1);

   // ---------------- registers ----------------
   logic [1:0]         mode_ff;
   logic               ign_en_ff, wen_ff, lpen_ff;
   logic signed [15:0] ign_lbl_ff;

   state_type state_ff, state_in;

   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic               rdv_ff, rdv_in;
   logic               first_ff, first_in;
   logic signed [31:0] m_ff, m_in;
   logic signed [15:0] lbl_ff, lbl_in;
   logic               lpos_ff, lpos_in;
   logic [MAX_CLASSES-1:0] wvalid_ff, wvalid_in;

   // exp pipeline
   logic               va_ff, vb_ff, biga_ff, bigb_ff;
   logic [33:0]        pa_ff, pa_in, pb_ff, pb_in;
   logic [11:0]        ra_ff;
   logic [31:0]        esum_ff, esum_in;

   // log
   logic [31:0]        s_ff, s_in;
   logic [4:0]         p_ff, p_in;
   logic [28:0]        lprod_ff, lprod_in;
   logic signed [31:0] lsum_ff, lsum_in;

   // loss
   logic signed [31:0] sel_ff, sel_in;
   logic signed [31:0] w_ff, w_in;
   logic signed [64:0] prod_ff, prod_in;
   logic signed [31:0] loss_ff, loss_in;
   logic signed [47:0] total_ff, total_in, den_ff, den_in;

   // divide
   logic [47:0]        rem_ff, rem_in, dsr_ff, dsr_in;
   logic [63:0]        dvd_ff, dvd_in, quo_ff, quo_in;
   logic [6:0]         dcnt_ff, dcnt_in;
   logic               dneg_ff, dneg_in;
   logic signed [31:0] red_ff, red_in;
   logic               nan_ff, nan_in;

   // result register
   logic               out_v_ff, out_v_in;
   logic [31:0]        out_amt_ff, out_amt_in;
   logic [1:0]         out_kind_ff, out_kind_in;
   logic               out_nan_ff, out_nan_in, out_last_ff, out_last_in;

   // ---------------- RAMs ----------------
   logic               sc_we, sc_re, wt_we, wt_re;
   logic [AW-1:0]      sc_waddr, sc_raddr, wt_waddr, wt_raddr;
   logic [31:0]        sc_rdata, wt_rdata;

   sce_ram #(.WIDTH(32), .DEPTH(MAX_CLASSES)) u_score (
      .clock(clock), .we(sc_we), .waddr(sc_waddr), .wdata(req_tdata[37:6]),
      .re(sc_re), .raddr(sc_raddr), .rdata(sc_rdata));

   sce_ram #(.WIDTH(32), .DEPTH(MAX_CLASSES)) u_weight (
      .clock(clock), .we(wt_we), .waddr(wt_waddr), .wdata(req_tdata[37:6]),
      .re(wt_re), .raddr(wt_raddr), .rdata(wt_rdata));

   // ---------------- register port ----------------
   logic csr_wr;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= RED_MEAN;
         ign_en_ff  <= 1'b0;
         ign_lbl_ff <= -16'sd100;
         wen_ff     <= 1'b0;
         lpen_ff    <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            REG_REDUCTION: mode_ff    <= csr_pwdata[1:0];
            REG_IGN_EN:    ign_en_ff  <= csr_pwdata[0];
            REG_IGN_LABEL: ign_lbl_ff <= csr_pwdata[15:0];
            REG_WEIGHT_EN: wen_ff     <= csr_pwdata[0];
            REG_LOGP_EN:   lpen_ff    <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_REDUCTION: csr_prdata = {30'd0, mode_ff};
         REG_IGN_EN:    csr_prdata = {31'd0, ign_en_ff};
         REG_IGN_LABEL: csr_prdata = {{16{ign_lbl_ff[15]}}, ign_lbl_ff};
         REG_WEIGHT_EN: csr_prdata = {31'd0, wen_ff};
         REG_LOGP_EN:   csr_prdata = {31'd0, lpen_ff};
         default:       csr_prdata = 32'd0;
      endcase
   end

   // ---------------- input decode ----------------
   logic        acc;
   logic [5:0]  in_slot;
   logic [15:0] in_label;
   assign req_tready = (state_ff == S_IDLE);
   assign acc        = req_tvalid && req_tready;
   assign in_slot    = req_tdata[5:0];
   assign in_label   = req_tdata[53:38];

   // ---------------- datapath helpers ----------------
   logic               out_free;
   logic               ignored, lvalid;
   logic [AW-1:0]      lidx;
   logic signed [31:0] x;
   logic signed [32:0] dexp, t;
   logic               big;
   logic [16:0]        va17, ve17;
   logic [33:0]        pa_rnd, pb_rnd;
   logic [15:0]        lt_lo, lt_hi;
   logic [29:0]        lprod_rnd;
   logic signed [33:0] lp_w;
   logic signed [31:0] lp;
   logic signed [32:0] nsel;
   logic signed [31:0] wsel;
   logic [47:0]        rem_sh_lo;
   logic [48:0]        rem_sh;
   logic [32:0]        qcap;
   logic               lp_last, more_out;

   assign out_free = !out_v_ff || rsp_tready;
   assign ignored  = ign_en_ff && (lbl_ff == ign_lbl_ff);
   assign lvalid   = !ignored && !lbl_ff[15] && ($unsigned(lbl_ff) < 16'(count_ff));
   assign lidx     = lbl_ff[AW-1:0];
   assign x        = sc_rdata;

   // exp argument: t = m - x, never negative
   assign dexp = 33'(x) - 33'(m_ff);
   assign t    = (dexp > 33'sd0) ? 33'sd0 : -dexp;
   assign big  = t >= 33'sd786432;
   assign pa_rnd = pa_ff + 34'd32768;
   assign va17   = pa_rnd[32:16];
   assign pb_rnd = pb_ff + 34'd32768;
   assign ve17   = bigb_ff ? 17'd0 : pb_rnd[32:16];

   // log interpolation
   assign lt_lo     = log_tab({1'b0, s_ff[30:27]});
   assign lt_hi     = log_tab(5'({1'b0, s_ff[30:27]}) + 5'd1);
   assign lprod_rnd = 30'(lprod_ff) + 30'd32768;

   assign lp_w = 34'(x) - 34'(m_ff) - 34'(lsum_ff);
   assign lp   = sat32(66'(lp_w));

   assign nsel = -33'(sel_ff);
   assign wsel = (!wen_ff || !wvalid_ff[lidx]) ? ONE_Q16 : $signed(wt_rdata);

   assign rem_sh_lo = rem_ff;
   assign rem_sh    = {rem_sh_lo, dvd_ff[63]};
   assign qcap      = (quo_ff > 64'h8000_0000) ? 33'h1_0000_0000 : quo_ff[32:0];

   // a later result follows the log-probabilities
   assign more_out = (mode_ff == RED_NONE) || lpos_ff;
   assign lp_last  = !more_out && (idx_ff == count_ff - CW'(1));

   // ---------------- sequencer ----------------
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      rdv_in    = 1'b0;
      first_in  = first_ff;
      m_in      = m_ff;
      lbl_in    = lbl_ff;
      lpos_in   = lpos_ff;
      wvalid_in = wvalid_ff;
      pa_in     = 34'(exp_int(t[19:16])) * 34'(exp_frac(t[15:12]));
      pb_in     = 34'(va17) * 34'(17'd65536 - 17'(ra_ff));
      esum_in   = esum_ff;
      s_in      = s_ff;
      p_in      = p_ff;
      lprod_in  = 29'(lt_hi - lt_lo) * 29'(s_ff[26:11]);
      lsum_in   = lsum_ff;
      sel_in    = sel_ff;
      w_in      = w_ff;
      prod_in   = prod_ff;
      loss_in   = loss_ff;
      total_in  = total_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      dvd_in    = dvd_ff;
      quo_in    = quo_ff;
      dcnt_in   = dcnt_ff;
      dneg_in   = dneg_ff;
      red_in    = red_ff;
      nan_in    = nan_ff;
      sc_we     = 1'b0;
      sc_waddr  = count_ff[AW-1:0];
      sc_re     = 1'b0;
      sc_raddr  = idx_ff[AW-1:0];
      wt_we     = 1'b0;
      wt_waddr  = in_slot[AW-1:0];
      wt_re     = 1'b0;
      wt_raddr  = lidx;
      out_v_in    = out_v_ff && !rsp_tready;
      out_amt_in  = out_amt_ff;
      out_kind_in = out_kind_ff;
      out_nan_in  = out_nan_ff;
      out_last_in = out_last_ff;

      unique case (state_ff)
         // take weight writes and scores
         S_IDLE: begin
            if (acc) begin
               if (req_tuser == KIND_WEIGHT) begin
                  if (in_slot < 6'(MAX_CLASSES)) begin
                     wt_we = 1'b1;
                     wvalid_in[in_slot[AW-1:0]] = 1'b1;
                  end
               end else begin
                  if (count_ff < CW'(MAX_CLASSES)) begin
                     sc_we    = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
                  if (req_tlast) begin
                     lbl_in   = in_label;
                     lpos_in  = req_tdata[54];
                     idx_in   = '0;
                     first_in = 1'b1;
                     state_in = S_MAXP;
                  end
               end
            end
         end
         // find the maximum score
         S_MAXP: begin
            if (idx_ff != count_ff) begin
               sc_re  = 1'b1;
               rdv_in = 1'b1;
               idx_in = idx_ff + CW'(1);
            end
            if (rdv_ff) begin
               first_in = 1'b0;
               if (first_ff || x > m_ff) m_in = x;
            end
            if (idx_ff == count_ff && !rdv_ff) begin
               idx_in   = '0;
               esum_in  = '0;
               state_in = S_EXPP;
            end
         end
         // accumulate the exp sum through the multiplier pipeline
         S_EXPP: begin
            if (idx_ff != count_ff) begin
               sc_re  = 1'b1;
               rdv_in = 1'b1;
               idx_in = idx_ff + CW'(1);
            end
            if (vb_ff) esum_in = esum_ff + 32'(ve17);
            if (idx_ff == count_ff && !rdv_ff && !va_ff && !vb_ff) begin
               s_in     = esum_ff;
               p_in     = 5'd31;
               state_in = S_NORM;
            end
         end
         // normalize the sum one bit per cycle
         S_NORM: begin
            if (s_ff[31]) begin
               state_in = S_LOGM;
            end else begin
               s_in = {s_ff[30:0], 1'b0};
               p_in = p_ff - 5'd1;
            end
         end
         S_LOGM: state_in = S_LOGS;
         S_LOGS: begin
            lsum_in  = 32'(p_ff - 5'd16) * 32'(LN2_Q16) + 32'(lt_lo)
                       + 32'(lprod_rnd[29:16]);
            idx_in   = '0;
            sel_in   = '0;
            state_in = S_LPRD;
         end
         // per-class log-probability
         S_LPRD: begin
            sc_re    = 1'b1;
            state_in = S_LPOUT;
         end
         S_LPOUT: begin
            if (!lpen_ff || out_free) begin
               if (lbl_ff == 16'(idx_ff)) sel_in = lp;
               if (lpen_ff) begin
                  out_v_in    = 1'b1;
                  out_amt_in  = lp;
                  out_kind_in = RK_LOGPROB;
                  out_nan_in  = 1'b0;
                  out_last_in = lp_last;
               end
               idx_in = idx_ff + CW'(1);
               if (idx_ff == count_ff - CW'(1)) state_in = S_WRD;
               else                              state_in = S_LPRD;
            end
         end
         S_WRD: begin
            wt_re    = 1'b1;
            state_in = S_LMUL;
         end
         S_LMUL: begin
            w_in     = lvalid ? wsel : 32'sd0;
            prod_in  = lvalid ? (65'(nsel) * 65'(wsel)) : 65'sd0;
            state_in = S_LACC;
         end
         // fold the loss into the batch totals and choose the next step
         S_LACC: begin
            loss_in  = sat32(66'(prod_ff >>> 16));
            total_in = sat48(66'(total_ff) + 66'(loss_in));
            if (!ignored) den_in = sat48(66'(den_ff) + 66'(wen_ff ? w_ff : ONE_Q16));
            count_in = '0;
            if (mode_ff == RED_NONE) begin
               state_in = S_POS;
               if (lpos_ff) begin
                  total_in = '0;
                  den_in   = '0;
               end
            end else if (!lpos_ff) begin
               state_in = S_IDLE;
            end else if (mode_ff == RED_MEAN) begin
               if (den_in == 48'sd0) begin
                  red_in   = '0;
                  nan_in   = 1'b1;
                  state_in = S_RED;
               end else begin
                  dneg_in  = total_in[47] ^ den_in[47];
                  dvd_in   = {(total_in[47] ? 48'(-total_in) : 48'(total_in)), 16'd0};
                  dsr_in   = den_in[47] ? 48'(-den_in) : 48'(den_in);
                  rem_in   = '0;
                  quo_in   = '0;
                  dcnt_in  = '0;
                  state_in = S_DIV;
               end
            end else begin
               red_in   = sat32(66'(total_in));
               nan_in   = 1'b0;
               state_in = S_RED;
            end
         end
         S_POS: begin
            if (out_free) begin
               out_v_in    = 1'b1;
               out_amt_in  = loss_ff;
               out_kind_in = RK_POSLOSS;
               out_nan_in  = 1'b0;
               out_last_in = 1'b1;
               state_in    = S_IDLE;
            end
         end
         // restoring divide, one quotient bit per cycle
         S_DIV: begin
            if (dcnt_ff[6]) begin
               red_in   = sat32(dneg_ff ? -66'(qcap) : 66'(qcap));
               nan_in   = 1'b0;
               state_in = S_RED;
            end else begin
               dvd_in  = {dvd_ff[62:0], 1'b0};
               dcnt_in = dcnt_ff + 7'd1;
               if (rem_sh >= {1'b0, dsr_ff}) begin
                  rem_in = 48'(rem_sh - {1'b0, dsr_ff});
                  quo_in = {quo_ff[62:0], 1'b1};
               end else begin
                  rem_in = rem_sh[47:0];
                  quo_in = {quo_ff[62:0], 1'b0};
               end
            end
         end
         S_RED: begin
            if (out_free) begin
               out_v_in    = 1'b1;
               out_amt_in  = red_ff;
               out_kind_in = RK_REDUCED;
               out_nan_in  = nan_ff;
               out_last_in = 1'b1;
               total_in    = '0;
               den_in      = '0;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rdv_ff    <= 1'b0;
         va_ff     <= 1'b0;
         vb_ff     <= 1'b0;
         wvalid_ff <= '0;
         total_ff  <= '0;
         den_ff    <= '0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rdv_ff    <= rdv_in;
         va_ff     <= rdv_ff && (state_ff == S_EXPP);
         vb_ff     <= va_ff;
         wvalid_ff <= wvalid_in;
         total_ff  <= total_in;
         den_ff    <= den_in;
         out_v_ff  <= out_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      first_ff    <= first_in;
      m_ff        <= m_in;
      lbl_ff      <= lbl_in;
      lpos_ff     <= lpos_in;
      pa_ff       <= pa_in;
      ra_ff       <= t[11:0];
      biga_ff     <= big;
      pb_ff       <= pb_in;
      bigb_ff     <= biga_ff;
      esum_ff     <= esum_in;
      s_ff        <= s_in;
      p_ff        <= p_in;
      lprod_ff    <= lprod_in;
      lsum_ff     <= lsum_in;
      sel_ff      <= sel_in;
      w_ff        <= w_in;
      prod_ff     <= prod_in;
      loss_ff     <= loss_in;
      rem_ff      <= rem_in;
      dsr_ff      <= dsr_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      dcnt_ff     <= dcnt_in;
      dneg_ff     <= dneg_in;
      red_ff      <= red_in;
      nan_ff      <= nan_in;
      out_amt_ff  <= out_amt_in;
      out_kind_ff <= out_kind_in;
      out_nan_ff  <= out_nan_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_amt_ff;
   assign rsp_tuser  = {out_nan_ff, out_kind_ff};
   assign rsp_tlast  = out_last_ff;

endmodule
